// ===== rtl/i2crm_pkg.sv =====
package i2crm_pkg;

  // Bus event codes carried in the opcode field.
  typedef enum logic [1:0] {
    OP_START  = 2'd0,
    OP_WRITE  = 2'd1,
    OP_READ   = 2'd2,
    OP_LOCAL  = 2'd3
  } opcode_e;

  // Fixed identification values.
  localparam logic [7:0] ID_VALUE  = 8'h35;
  localparam logic [7:0] VER_VALUE = 8'h04;
  localparam logic [7:0] KEEP_MASK = 8'h7F;
  localparam logic [7:0] MUX_MASK  = 8'h01;

  // Register addresses.
  localparam logic [7:0] ADDR_ID  = 8'h10;
  localparam logic [7:0] ADDR_VER = 8'h12;
  localparam logic [7:0] ADDR_CH1 = 8'h20;
  localparam logic [7:0] ADDR_CH3 = 8'h22;
  localparam logic [7:0] ADDR_SUM = 8'h23;
  localparam logic [7:0] ADDR_AUX = 8'h24;
  localparam logic [7:0] ADDR_MUX = 8'h26;
  localparam logic [7:0] ADDR_VLO = 8'h30;
  localparam logic [7:0] ADDR_VHI = 8'h37;

  localparam int NumChannels = 3;
  localparam int NumStatus   = 10;
  localparam int StatusIdxW  = $clog2(NumStatus);
  localparam int ChanIdxW    = $clog2(NumChannels);

  typedef struct packed {
    logic                  hit;
    logic [StatusIdxW-1:0] idx;
  } status_slot_t;

  // Maps an address to its slot in the status byte bank.
  function automatic status_slot_t status_slot(input logic [7:0] addr);
    status_slot_t s;
    logic [7:0]   off;
    s   = '0;
    off = addr - ADDR_VLO;
    if (addr == ADDR_SUM) begin
      s.hit = 1'b1;
      s.idx = StatusIdxW'(0);
    end else if (addr == ADDR_AUX) begin
      s.hit = 1'b1;
      s.idx = StatusIdxW'(1);
    end else if (addr >= ADDR_VLO && addr <= ADDR_VHI) begin
      s.hit = 1'b1;
      s.idx = StatusIdxW'(off[2:0]) + StatusIdxW'(2);
    end
    return s;
  endfunction

  // Reset value of a status slot: its own register address.
  function automatic logic [7:0] status_addr(input logic [StatusIdxW-1:0] idx);
    logic [7:0] a;
    case (idx)
      StatusIdxW'(0): a = ADDR_SUM;
      StatusIdxW'(1): a = ADDR_AUX;
      default:        a = ADDR_VLO + 8'(idx - StatusIdxW'(2));
    endcase
    return a;
  endfunction

endpackage

// ===== rtl/i2c_slave_register_map.sv =====
// A word's result is registered in the result register when the word is accepted.
// Throughput: one word per cycle; all register updates are done in the cycle
// of acceptance, and the single result register only blocks while it is stalled.
// Reset: asynchronous, active low. The pointer and all control bits are cleared,
// mux enable and first-power set, and each status byte loads its own address.
module i2c_slave_register_map
  import i2crm_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] opcode_i,
  input  logic [7:0] data_byte_i,
  input  logic [7:0] local_index_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] read_data_o,
  output logic       read_valid_o,
  output logic [7:0] pointer_now_o,
  output logic       mux_enable_o,
  output logic       mux_written_o,
  output logic       first_power_o,
  output logic [7:0] channel_one_o,
  output logic [7:0] channel_two_o,
  output logic [7:0] channel_three_o
);

  // Register map state. The status bank is small enough to sit in flops and is
  // read at the pointer through a ten-way select.
  logic [7:0] pointer_q, pointer_d;
  logic       armed_q, armed_d;
  logic [7:0] chan_q [NumChannels];
  logic [7:0] chan_d [NumChannels];
  logic       mux_ctrl_q, mux_ctrl_d;
  logic       mux_seen_q, mux_seen_d;
  logic       power_first_q, power_first_d;
  logic [7:0] status_q [NumStatus];
  logic [7:0] status_d [NumStatus];

  // Result register.
  logic       out_valid_q, out_valid_d;
  logic [7:0] rdata_q, rdata_d;
  logic       rvalid_q, rvalid_d;

  logic          in_accept;
  opcode_e       op;
  status_slot_t  ptr_slot;
  status_slot_t  loc_slot;
  logic          ptr_is_chan;
  logic          loc_is_chan;
  logic [7:0]    read_byte;

  // The result register drains in the same cycle it refills, so input only
  // stalls while a finished word is held by the downstream side.
  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign op         = opcode_e'(opcode_i);

  assign ptr_slot    = status_slot(pointer_q);
  assign loc_slot    = status_slot(local_index_i);
  assign ptr_is_chan = (pointer_q >= ADDR_CH1) && (pointer_q <= ADDR_CH3);
  assign loc_is_chan = (local_index_i >= ADDR_CH1) && (local_index_i <= ADDR_CH3);

  // Read map at the current pointer; unmapped addresses read as zero.
  always_comb begin
    read_byte = '0;
    if (pointer_q == ADDR_ID) begin
      read_byte = ID_VALUE;
    end else if (pointer_q == ADDR_VER) begin
      read_byte = VER_VALUE;
    end else if (ptr_is_chan) begin
      read_byte = chan_q[pointer_q[ChanIdxW-1:0]];
    end else if (pointer_q == ADDR_MUX) begin
      read_byte = {7'd0, mux_ctrl_q};
    end else if (ptr_slot.hit) begin
      read_byte = status_q[ptr_slot.idx];
    end
  end

  // Next-state logic for one bus event.
  always_comb begin
    pointer_d     = pointer_q;
    armed_d       = armed_q;
    chan_d        = chan_q;
    mux_ctrl_d    = mux_ctrl_q;
    mux_seen_d    = mux_seen_q;
    power_first_d = power_first_q;
    status_d      = status_q;
    rdata_d       = '0;
    rvalid_d      = 1'b0;
    case (op)
      OP_START: begin
        // A repeated start re-arms capture and leaves the pointer alone.
        armed_d = 1'b1;
      end
      OP_WRITE: begin
        if (armed_q) begin
          pointer_d = data_byte_i;
          armed_d   = 1'b0;
        end else begin
          if (ptr_is_chan) begin
            // The host may clear the fault bit but never set it.
            chan_d[pointer_q[ChanIdxW-1:0]] =
              (chan_q[pointer_q[ChanIdxW-1:0]] | KEEP_MASK) & data_byte_i;
          end else if (pointer_q == ADDR_MUX) begin
            mux_ctrl_d = |(data_byte_i & MUX_MASK);
            mux_seen_d = 1'b1;
          end
          pointer_d = pointer_q + 8'd1;
        end
      end
      OP_READ: begin
        rdata_d  = read_byte;
        rvalid_d = 1'b1;
        // Reading the auxiliary register acknowledges the first power-up.
        if (pointer_q == ADDR_AUX) begin
          power_first_d = 1'b0;
        end
        pointer_d = pointer_q + 8'd1;
      end
      OP_LOCAL: begin
        // Local updates store the full byte and never touch the pointer.
        if (loc_is_chan) begin
          chan_d[local_index_i[ChanIdxW-1:0]] = data_byte_i;
        end else if (loc_slot.hit) begin
          status_d[loc_slot.idx] = data_byte_i;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (in_accept) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pointer_q     <= '0;
      armed_q       <= 1'b0;
      mux_ctrl_q    <= 1'b1;
      mux_seen_q    <= 1'b0;
      power_first_q <= 1'b1;
      out_valid_q   <= 1'b0;
      for (int i = 0; i < NumChannels; i++) begin
        chan_q[i] <= '0;
      end
      for (int i = 0; i < NumStatus; i++) begin
        status_q[i] <= status_addr(StatusIdxW'(i));
      end
    end else begin
      out_valid_q <= out_valid_d;
      if (in_accept) begin
        pointer_q     <= pointer_d;
        armed_q       <= armed_d;
        chan_q        <= chan_d;
        mux_ctrl_q    <= mux_ctrl_d;
        mux_seen_q    <= mux_seen_d;
        power_first_q <= power_first_d;
        status_q      <= status_d;
      end
    end
  end

  // Result payload; it only loads on acceptance, which cannot happen while
  // the held word is stalled.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      rdata_q  <= rdata_d;
      rvalid_q <= rvalid_d;
    end
  end

  // The state outputs come straight from the state flops, which change only
  // together with the result register.
  assign out_valid_o     = out_valid_q;
  assign read_data_o     = rdata_q;
  assign read_valid_o    = rvalid_q;
  assign pointer_now_o   = pointer_q;
  assign mux_enable_o    = mux_ctrl_q;
  assign mux_written_o   = mux_seen_q;
  assign first_power_o   = power_first_q;
  assign channel_one_o   = chan_q[0];
  assign channel_two_o   = chan_q[1];
  assign channel_three_o = chan_q[2];

  // A result that is not a host read never carries read data.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !read_valid_o |-> read_data_o == 8'd0)
    else $error("read data nonzero on a non-read result");

  // The first-power flag can only be cleared.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$rose(power_first_q))
    else $error("first-power flag was set again");

  // Once the mux register has been written, the written flag stays up.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$fell(mux_seen_q))
    else $error("mux written flag dropped");

  // A local update leaves the pointer and the capture state alone.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && op == OP_LOCAL |=> $stable(pointer_q) && $stable(armed_q))
    else $error("local update disturbed the pointer");

  // A host read at the auxiliary register clears the first-power flag.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && op == OP_READ && pointer_q == ADDR_AUX |=> !power_first_q)
    else $error("auxiliary read did not clear first-power");

endmodule

// ===== dv/testbench.sv =====
module testbench;
  import i2crm_pkg::*;

  // One result word of the register map, as it shows on the output ports.
  typedef struct packed {
    logic [7:0] read_data;
    logic       read_valid;
    logic [7:0] pointer_now;
    logic       mux_enable;
    logic       mux_written;
    logic       first_power;
    logic [7:0] channel_one;
    logic [7:0] channel_two;
    logic [7:0] channel_three;
  } map_result_t;

  // One row of the directed table. Where typed is set, res is the result
  // written out by hand; otherwise the predictor supplies the expectation.
  typedef struct packed {
    opcode_e     op;
    logic [7:0]  data;
    logic [7:0]  idx;
    logic        typed;
    map_result_t res;
  } bus_row_t;

  localparam int RandomWords  = 900;
  localparam int CycleLimit   = 200000;
  localparam int DrainCycles  = 4;
  localparam int IdlePercent  = 18;
  // Words in this window are sent, and results taken, with no idling at all.
  localparam int QuietFirst   = 300;
  localparam int QuietLast    = 500;

  logic       clk_i           = 1'b0;
  logic       rst_ni          = 1'b0;
  logic       in_valid_i      = 1'b0;
  logic       in_stall_o;
  logic [1:0] opcode_i        = OP_START;
  logic [7:0] data_byte_i     = 8'h00;
  logic [7:0] local_index_i   = 8'h00;
  logic       out_valid_o;
  logic       out_stall_i     = 1'b0;
  logic [7:0] read_data_o;
  logic       read_valid_o;
  logic [7:0] pointer_now_o;
  logic       mux_enable_o;
  logic       mux_written_o;
  logic       first_power_o;
  logic [7:0] channel_one_o;
  logic [7:0] channel_two_o;
  logic [7:0] channel_three_o;

  i2c_slave_register_map u_top (.*);

  // Free-running clock with a period of 10.
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Predictor state: a private copy of everything the block remembers.
  logic [7:0] map_ptr;
  logic       capture_armed;
  logic [7:0] chan_bytes [NumChannels];
  logic       mux_en;
  logic       mux_seen;
  logic       power_first;
  logic [7:0] status_bytes [NumStatus];

  map_result_t expected_results [$];
  bus_row_t    directed_rows [$];
  int          error_count = 0;
  int          words_sent  = 0;
  int          cycle_count = 0;
  logic        no_idle     = 1'b0;

  // Every mismatch and every stray result goes through here: one line, one count.
  task automatic report_error(input string msg);
    error_count++;
    $display("ERROR at cycle %0d: %s", cycle_count, msg);
  endtask

  task automatic compare_field(input string name, input int got, input int want);
    if (got != want) begin
      report_error($sformatf("%s got 0x%02h expected 0x%02h", name, got, want));
    end
  endtask

  // Slot of a status byte in the bank, or -1 when the address holds none.
  function automatic int status_index(input logic [7:0] addr);
    if (addr == ADDR_SUM) return 0;
    if (addr == ADDR_AUX) return 1;
    if (addr >= ADDR_VLO && addr <= ADDR_VHI) return 2 + int'(addr - ADDR_VLO);
    return -1;
  endfunction

  // The byte the host sees when it reads the given address.
  function automatic logic [7:0] mapped_byte(input logic [7:0] addr);
    int slot;
    slot = status_index(addr);
    if (addr == ADDR_ID) return ID_VALUE;
    if (addr == ADDR_VER) return VER_VALUE;
    if (addr >= ADDR_CH1 && addr <= ADDR_CH3) return chan_bytes[int'(addr - ADDR_CH1)];
    if (addr == ADDR_MUX) return {7'd0, mux_en};
    if (slot >= 0) return status_bytes[slot];
    return 8'h00;
  endfunction

  task automatic reset_map_model();
    map_ptr       = 8'h00;
    capture_armed = 1'b0;
    mux_en        = 1'b1;
    mux_seen      = 1'b0;
    power_first   = 1'b1;
    for (int i = 0; i < NumChannels; i++) chan_bytes[i] = 8'h00;
    status_bytes[0] = ADDR_SUM;
    status_bytes[1] = ADDR_AUX;
    for (int i = 0; i < 8; i++) status_bytes[2 + i] = ADDR_VLO + 8'(i);
  endtask

  // Applies one bus event to the predictor state and returns the result word.
  task automatic predict_bus_event(input opcode_e op, input logic [7:0] data,
                                   input logic [7:0] idx, output map_result_t res);
    int slot;
    res = '0;
    case (op)
      // A start, repeated or not, only arms pointer capture.
      OP_START: begin
        capture_armed = 1'b1;
      end
      OP_WRITE: begin
        if (capture_armed) begin
          map_ptr       = data;
          capture_armed = 1'b0;
        end else begin
          // Channel bytes keep old bit 7 AND new bit 7: the fault bit
          // can be cleared by the host but never set.
          if (map_ptr >= ADDR_CH1 && map_ptr <= ADDR_CH3) begin
            chan_bytes[int'(map_ptr - ADDR_CH1)] =
              (chan_bytes[int'(map_ptr - ADDR_CH1)] | KEEP_MASK) & data;
          end else if (map_ptr == ADDR_MUX) begin
            mux_en   = data[0];
            mux_seen = 1'b1;
          end
          map_ptr = map_ptr + 8'd1;
        end
      end
      // A read is served even while capture is armed, and leaves it armed.
      OP_READ: begin
        res.read_data  = mapped_byte(map_ptr);
        res.read_valid = 1'b1;
        if (map_ptr == ADDR_AUX) power_first = 1'b0;
        map_ptr = map_ptr + 8'd1;
      end
      // Local updates store the full byte and leave pointer and capture alone.
      default: begin
        slot = status_index(idx);
        if (idx >= ADDR_CH1 && idx <= ADDR_CH3) begin
          chan_bytes[int'(idx - ADDR_CH1)] = data;
        end else if (slot >= 0) begin
          status_bytes[slot] = data;
        end
      end
    endcase
    res.pointer_now   = map_ptr;
    res.mux_enable    = mux_en;
    res.mux_written   = mux_seen;
    res.first_power   = power_first;
    res.channel_one   = chan_bytes[0];
    res.channel_two   = chan_bytes[1];
    res.channel_three = chan_bytes[2];
  endtask

  function automatic map_result_t typed_result(
    input logic [7:0] rd, input logic rv, input logic [7:0] ptr, input logic mux,
    input logic seen, input logic pwr, input logic [7:0] c1, input logic [7:0] c2,
    input logic [7:0] c3);
    return '{rd, rv, ptr, mux, seen, pwr, c1, c2, c3};
  endfunction

  // Sends one word. Valid is only lowered when a gap is actually taken, so a
  // back-to-back word never sees valid dropped and raised in the same step.
  // The expectation is pushed at the edge where the word is accepted.
  task automatic send_word(input opcode_e op, input logic [7:0] data,
                           input logic [7:0] idx, input logic typed,
                           input map_result_t typed_res);
    map_result_t pred;
    if (!no_idle && $urandom_range(0, 99) < IdlePercent) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while (!no_idle && $urandom_range(0, 99) < IdlePercent);
    end
    in_valid_i    <= 1'b1;
    opcode_i      <= op;
    data_byte_i   <= data;
    local_index_i <= idx;
    do @(posedge clk_i); while (in_stall_o);
    predict_bus_event(op, data, idx, pred);
    expected_results.push_back(typed ? typed_res : pred);
    words_sent++;
    no_idle <= (words_sent >= QuietFirst && words_sent < QuietLast);
  endtask

  // Addresses that matter: the ID and version bytes, the mux and auxiliary bytes, the channel
  // and status windows with their neighbors, the top of the map for the wrap, or anything.
  function automatic logic [7:0] pick_address();
    case ($urandom_range(0, 5))
      0: return 8'($urandom_range(8'h1E, 8'h27));
      1: return 8'($urandom_range(8'h2E, 8'h38));
      2: return ($urandom_range(0, 1) != 0) ? ADDR_ID : ADDR_VER;
      3: return 8'($urandom_range(8'hFC, 8'hFF));
      4: return ($urandom_range(0, 1) != 0) ? ADDR_MUX : ADDR_AUX;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Result checker. Sampling happens at the edge, before any of this edge's
  // updates land, so the handshake is seen as it stood when the word moved.
  always @(posedge clk_i) begin : result_check
    map_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_results.size() == 0) begin
        report_error("result word with no expectation waiting");
      end else begin
        want = expected_results.pop_front();
        compare_field("read_data", read_data_o, want.read_data);
        compare_field("read_valid", read_valid_o, want.read_valid);
        compare_field("pointer_now", pointer_now_o, want.pointer_now);
        compare_field("mux_enable", mux_enable_o, want.mux_enable);
        compare_field("mux_written", mux_written_o, want.mux_written);
        compare_field("first_power", first_power_o, want.first_power);
        compare_field("channel_one", channel_one_o, want.channel_one);
        compare_field("channel_two", channel_two_o, want.channel_two);
        compare_field("channel_three", channel_three_o, want.channel_three);
      end
    end
  end

  // Result-side stall, the cycle counter and the watchdog.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    out_stall_i <= !no_idle && ($urandom_range(0, 99) < IdlePercent);
    if (cycle_count == CycleLimit) begin
      $display("testbench failed");
      $finish;
    end
  end

  initial begin : stimulus
    int burst;
    int pick;
    logic is_read;

    // Directed table. The first rows follow the state straight out of reset
    // and carry their results typed in; the rest are left to the predictor.
    // Host read of an unmapped address right after reset.
    directed_rows.push_back('{OP_READ, 8'h00, 8'h00, 1'b1,
      typed_result(8'h00, 1'b1, 8'h01, 1'b1, 1'b0, 1'b1, 8'h00, 8'h00, 8'h00)});
    directed_rows.push_back('{OP_START, 8'h00, 8'h00, 1'b1,
      typed_result(8'h00, 1'b0, 8'h01, 1'b1, 1'b0, 1'b1, 8'h00, 8'h00, 8'h00)});
    // First written byte after a start sets the pointer to the ID byte.
    directed_rows.push_back('{OP_WRITE, ADDR_ID, 8'h00, 1'b1,
      typed_result(8'h00, 1'b0, 8'h10, 1'b1, 1'b0, 1'b1, 8'h00, 8'h00, 8'h00)});
    directed_rows.push_back('{OP_READ, 8'h00, 8'h00, 1'b1,
      typed_result(ID_VALUE, 1'b1, 8'h11, 1'b1, 1'b0, 1'b1, 8'h00, 8'h00, 8'h00)});
    directed_rows.push_back('{OP_READ, 8'h00, 8'h00, 1'b1,
      typed_result(8'h00, 1'b1, 8'h12, 1'b1, 1'b0, 1'b1, 8'h00, 8'h00, 8'h00)});
    directed_rows.push_back('{OP_READ, 8'h00, 8'h00, 1'b1,
      typed_result(VER_VALUE, 1'b1, 8'h13, 1'b1, 1'b0, 1'b1, 8'h00, 8'h00, 8'h00)});
    directed_rows.push_back('{OP_START, 8'h00, 8'h00, 1'b1,
      typed_result(8'h00, 1'b0, 8'h13, 1'b1, 1'b0, 1'b1, 8'h00, 8'h00, 8'h00)});
    directed_rows.push_back('{OP_WRITE, ADDR_CH1, 8'h00, 1'b1,
      typed_result(8'h00, 1'b0, 8'h20, 1'b1, 1'b0, 1'b1, 8'h00, 8'h00, 8'h00)});
    // All ones into channel one: the fault bit stays clear.
    directed_rows.push_back('{OP_WRITE, 8'hFF, 8'h00, 1'b1,
      typed_result(8'h00, 1'b0, 8'h21, 1'b1, 1'b0, 1'b1, 8'h7F, 8'h00, 8'h00)});
    // A local update may set the fault bit; the host may then clear the rest.
    directed_rows.push_back('{OP_LOCAL, 8'hFF, 8'h21, 1'b0, map_result_t'('0)});
    directed_rows.push_back('{OP_WRITE, 8'h80, 8'h00, 1'b0, map_result_t'('0)});
    directed_rows.push_back('{OP_WRITE, 8'h00, 8'h00, 1'b0, map_result_t'('0)});
    // Summary byte, then the auxiliary byte, whose read clears first-power.
    directed_rows.push_back('{OP_READ, 8'h00, 8'h00, 1'b0, map_result_t'('0)});
    directed_rows.push_back('{OP_READ, 8'h00, 8'h00, 1'b0, map_result_t'('0)});
    // A read while capture is armed, then a repeated start.
    directed_rows.push_back('{OP_START, 8'h00, 8'h00, 1'b0, map_result_t'('0)});
    directed_rows.push_back('{OP_READ, 8'h00, 8'h00, 1'b0, map_result_t'('0)});
    directed_rows.push_back('{OP_START, 8'h00, 8'h00, 1'b0, map_result_t'('0)});
    directed_rows.push_back('{OP_WRITE, 8'h25, 8'h00, 1'b0, map_result_t'('0)});
    // Write to a hole stores nothing; the next one lands on the mux control.
    directed_rows.push_back('{OP_WRITE, 8'h11, 8'h00, 1'b0, map_result_t'('0)});
    directed_rows.push_back('{OP_WRITE, 8'hFE, 8'h00, 1'b0, map_result_t'('0)});
    // Pointer at the top of the map wraps to zero on the read.
    directed_rows.push_back('{OP_START, 8'h00, 8'h00, 1'b0, map_result_t'('0)});
    directed_rows.push_back('{OP_WRITE, 8'hFF, 8'h00, 1'b0, map_result_t'('0)});
    directed_rows.push_back('{OP_READ, 8'h00, 8'h00, 1'b0, map_result_t'('0)});
    // Local updates: top status byte, an ignored index, channel one bit 7.
    directed_rows.push_back('{OP_LOCAL, 8'hA5, ADDR_VHI, 1'b0, map_result_t'('0)});
    directed_rows.push_back('{OP_LOCAL, 8'h5A, 8'hFF, 1'b0, map_result_t'('0)});
    directed_rows.push_back('{OP_LOCAL, 8'h80, ADDR_CH1, 1'b0, map_result_t'('0)});

    reset_map_model();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i]) begin
      send_word(directed_rows[i].op, directed_rows[i].data, directed_rows[i].idx,
                directed_rows[i].typed, directed_rows[i].res);
    end

    // Random part. Most of it is complete host transactions: a start, the
    // pointer byte, then a burst of reads or writes with random content.
    // The rest is local updates and loose words in any order.
    while (words_sent < RandomWords + directed_rows.size()) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        send_word(OP_START, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  1'b0, '0);
        // Now and then a repeated start before or after the pointer byte.
        if ($urandom_range(0, 9) == 0) begin
          send_word(OP_START, 8'h00, 8'h00, 1'b0, '0);
        end
        send_word(OP_WRITE, pick_address(), 8'($urandom_range(0, 255)), 1'b0, '0);
        if ($urandom_range(0, 9) == 0) begin
          send_word(OP_START, 8'h00, 8'h00, 1'b0, '0);
          send_word(OP_WRITE, pick_address(), 8'h00, 1'b0, '0);
        end
        burst   = $urandom_range(1, 6);
        is_read = ($urandom_range(0, 1) != 0);
        for (int b = 0; b < burst; b++) begin
          if ($urandom_range(0, 7) == 0) begin
            send_word(OP_LOCAL, 8'($urandom_range(0, 255)), pick_address(), 1'b0, '0);
          end else if (is_read) begin
            send_word(OP_READ, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                      1'b0, '0);
          end else begin
            send_word(OP_WRITE, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                      1'b0, '0);
          end
        end
      end else if (pick < 85) begin
        send_word(OP_LOCAL, 8'($urandom_range(0, 255)), pick_address(), 1'b0, '0);
      end else begin
        send_word(opcode_e'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)), 1'b0, '0);
      end
    end

    // Drain: wait for every expected word, then keep watching for stray results.
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (error_count == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
